FILE: hdl/pem_pkg.sv
// ----------------------------------------------------------------------------
// pem_pkg
// Shared types, constants and helpers for the Prewitt edge magnitude unit.
// ----------------------------------------------------------------------------
package pem_pkg;

  localparam int MAX_WIDTH_DEF = 512;
  localparam int MAX_HEIGHT    = 512;
  localparam int PIX_W         = 8;
  localparam int CFG_W         = 10;
  localparam int CFG_ADDR_W    = 1;
  localparam int ROW_W         = 9;
  localparam int POS_W         = 9;
  localparam int QUOT_W        = 7;
  localparam int OUT_DATA_W    = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

  // floor(x / 3) for 8-bit x via reciprocal multiply (171 / 512)
  function automatic logic [QUOT_W-1:0] div3(input logic [PIX_W-1:0] x);
    logic [16:0] p;
    p = 17'(x) * 17'd171;
    return p[15:9];
  endfunction

endpackage

FILE: hdl/pem_ram.sv
// ----------------------------------------------------------------------------
// pem_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/prewitt_edge_magnitude_unit.sv
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude_unit
// Streaming horizontal Prewitt edge magnitude over a 3x3 window.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one greyscale pixel per transaction, raster order.
//   out_* : one result per interior window centre; tdata carries magnitude,
//           centre row and centre column, tlast marks the frame's last result.
//   cfg_* : image width / height writes, only while the unit is idle.
// Both rows above the current pixel sit in one line RAM (upper/middle pair per
// column). A pixel's RAM read is issued on acceptance; the window update and
// write-back happen when the item leaves stage 1, and the result lands in the
// output register that drives out_tvalid. Throughput is 1 pixel per cycle
// while the receiver keeps up, limited by the single read and single write
// port of the line RAM; same-column accesses are a full row apart.
// A result is emitted when the pixel one row below and one column right of
// its centre arrives; border centres give no result.
// Reset clears counters, window and valids; RAM contents stay undefined.
// A stalled receiver holds the output register; the pipeline stage behind it
// keeps accepting until it too is full, then in_tready drops.
// ----------------------------------------------------------------------------
module prewitt_edge_magnitude_unit #(
  parameter int MAX_WIDTH = pem_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pem_pkg::PIX_W-1:0]         in_tdata,   // [7:0] pixel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pem_pkg::OUT_DATA_W-1:0]    out_tdata,  // [7:0] edge_magnitude,
                                                        // [16:8] center_row,
                                                        // [25:17] center_col
  output logic                              out_tlast,  // frame_last
  input  logic                              cfg_we,
  input  logic [pem_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pem_pkg::CFG_W-1:0]         cfg_wdata
);
  import pem_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CNT_W = CW + 1;

  logic [CFG_W-1:0] img_w_r, img_h_r;
  logic [CNT_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_inc;
  logic [CFG_W-1:0] row_inc;

  logic             s1_v_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [CW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;

  logic [QUOT_W-1:0] left_q_r [3];
  logic [QUOT_W-1:0] mid_q_r  [3];
  logic [QUOT_W-1:0] right_q  [3];

  line_pair_t ram_rd, ram_wd;
  logic       in_acc, adv, produce, last_hit;

  logic signed [CFG_W-1:0] grad;
  logic        [CFG_W-1:0] mag;
  logic        [PIX_W-1:0] mag_sat;
  logic        [CW-1:0]    col_m1;
  logic        [ROW_W-1:0] row_m1;

  logic             out_v_r, out_v_nxt;
  logic [PIX_W-1:0] out_mag_r;
  logic [POS_W-1:0] out_row_r, out_col_r;
  logic             out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= CFG_W'(MAX_WIDTH_DEF);
      img_h_r <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  img_w_r <= cfg_wdata;
        REG_IMAGE_HEIGHT: img_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_w_r < CFG_W'(3)) begin
      w_eff = CNT_W'(3);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(img_w_r);
    end
    if (img_h_r < CFG_W'(3)) begin
      h_eff = CFG_W'(3);
    end else if (img_h_r > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_h_r;
    end
  end

  // handshake
  assign produce   = (s1_row_r >= ROW_W'(2)) && (s1_col_r >= CW'(2));
  assign adv       = s1_v_r && (!produce || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // raster counters
  always_comb begin
    col_inc = CNT_W'(col_r) + CNT_W'(1);
    row_inc = CFG_W'(row_r) + CFG_W'(1);
    col_nxt = col_inc[CW-1:0];
    row_nxt = row_r;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line RAM: read on acceptance, write back when the item leaves stage 1
  assign ram_wd.upper  = ram_rd.middle;
  assign ram_wd.middle = s1_px_r;

  pem_ram #(
    .WIDTH ($bits(line_pair_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_col_r),
    .wdata (ram_wd),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rd)
  );

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r  <= in_tdata;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  // window holds column quotients
  assign right_q[0] = div3(ram_rd.upper);
  assign right_q[1] = div3(ram_rd.middle);
  assign right_q[2] = div3(s1_px_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        left_q_r[k] <= '0;
        mid_q_r[k]  <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k < 3; k++) begin
        left_q_r[k] <= mid_q_r[k];
        mid_q_r[k]  <= right_q[k];
      end
    end
  end

  always_comb begin
    grad = '0;
    for (int k = 0; k < 3; k++) begin
      grad = grad + $signed(CFG_W'(right_q[k])) - $signed(CFG_W'(left_q_r[k]));
    end
    mag     = grad[CFG_W-1] ? CFG_W'(-grad) : CFG_W'(grad);
    mag_sat = (mag > CFG_W'(255)) ? 8'hFF : mag[PIX_W-1:0];
    col_m1  = s1_col_r - CW'(1);
    row_m1  = s1_row_r - ROW_W'(1);
    last_hit = (CFG_W'(s1_row_r) == h_eff - CFG_W'(1)) &&
               (CNT_W'(s1_col_r) == w_eff - CNT_W'(1));
  end

  // output register
  always_comb begin
    out_v_nxt = out_v_r && !out_tready;
    if (adv && produce) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && produce) begin
      out_mag_r  <= mag_sat;
      out_row_r  <= row_m1;
      out_col_r  <= POS_W'(col_m1);
      out_last_r <= last_hit;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'({out_col_r, out_row_r, out_mag_r});
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_ram_we_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> s1_v_r)
    else $error("line RAM written without an item in stage 1");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!s1_v_r || adv))
    else $error("stage 1 overwritten while held");

  a_rd_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> $stable(ram_rd))
    else $error("line RAM read data changed under a held item");

  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_row_r != '0 && out_col_r != '0))
    else $error("border centre emitted");
`endif

endmodule
